// ===== rtl/bbt_pkg.sv =====
// Package: shared types, constants and helpers for the bouncing ball table.
package bbt_pkg;

    localparam int BALLS   = 128;
    localparam int IDX_W   = $clog2(BALLS);
    localparam int POS_W   = 18;
    localparam int VEL_W   = 16;

    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_DRAG   = 3'd2,
        CFG_GRAV   = 3'd3,
        CFG_JUMPV  = 3'd4,
        CFG_CHANCE = 3'd5,
        CFG_SEED   = 3'd6
    } t_cfg_idx;

    localparam logic [2:0] TILE_EMPTY = 3'd0;
    localparam logic [2:0] TILE_VWALL = 3'd1;
    localparam logic [2:0] TILE_HWALL = 3'd2;
    localparam logic [2:0] TILE_BALL0 = 3'd3;

    // One ball entry as stored in the table.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic        [15:0]      bounce;
        logic        [10:0]      radius;
        logic        [2:0]       texture;
    } t_ball;

    // Operand pair for the shared multiplier.
    typedef struct packed {
        logic signed [17:0] a;
        logic signed [17:0] b;
    } t_mul_req;

    // Arithmetic shift with truncation toward zero for a Q16 product.
    function automatic logic signed [VEL_W-1:0] trunc16(input logic signed [35:0] p);
        logic signed [35:0] t;
        t = p + ((p < 0) ? 36'sd65535 : 36'sd0);
        return VEL_W'(t >>> 16);
    endfunction

    function automatic logic signed [VEL_W-1:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) return 16'sh7fff;
        if (v < -18'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== rtl/bbt_mul.sv =====
// Shared signed 18x18 multiplier with a registered product.
module bbt_mul
    import bbt_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic signed [35:0] o_prod
);

    logic signed [35:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/bouncing_ball_table_with_circle_raster.sv =====
// Top level: ball table, physics tick and pixel query sequencer.
//
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_command .. i_query_y
//  out     | o_valid | i_ready | o_tile_code, o_hit, o_hit_ball
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// Load, unused command and wall pixels: result valid the cycle after the transfer.
// Table scan (tick, pixel query): invalid entries pass S_RD, S_CHK only; a tick
// runs S_AX, S_AY, S_GRAV, S_DRAG per valid ball, a query S_PX, S_PY, S_PCMP per
// ball tested, stopping at the first hit; the single shared multiplier and the
// single table port set the pace. Reset clears valid bits, restores config defaults.
// o_ready is low while an item is worked on or its result has not been taken.
module bouncing_ball_table_with_circle_raster
    import bbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_ball_index,
    input  logic [15:0] i_load_pos_x,
    input  logic [15:0] i_load_pos_y,
    input  logic signed [15:0] i_load_vel_x,
    input  logic signed [15:0] i_load_vel_y,
    input  logic [15:0] i_load_bounce,
    input  logic [10:0] i_load_radius,
    input  logic [2:0]  i_load_texture,
    input  logic [7:0]  i_query_x,
    input  logic [7:0]  i_query_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_tile_code,
    output logic        o_hit,
    output logic [6:0]  o_hit_ball,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_CHK   = 11'b00000000100,
        S_PX    = 11'b00000001000,
        S_PY    = 11'b00000010000,
        S_PCMP  = 11'b00000100000,
        S_AX    = 11'b00001000000,
        S_AY    = 11'b00010000000,
        S_GRAV  = 11'b00100000000,
        S_DRAG  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [7:0]  r_width, r_height;
    logic [15:0] r_drag, r_chance;
    logic signed [15:0] r_grav, r_jumpv;
    logic [31:0] r_lfsr;
    logic [BALLS-1:0] r_valid_bits;

    t_ball r_mem [BALLS];
    t_ball r_rd;
    t_ball r_cur;
    logic [IDX_W:0] r_idx;
    logic [IDX_W-1:0] w_idx;
    logic        r_cmd_tick;
    logic [7:0]  r_qx, r_qy;
    logic [2:0]  r_sub;
    logic signed [35:0] r_acc;
    logic        r_floor;
    logic [2:0]  r_tile;
    logic        r_hit;
    logic [6:0]  r_hit_ball;
    t_ball       w_wb;

    t_mul_req w_req;
    logic signed [35:0] w_prod;

    bbt_mul u_mul (.i_clk(i_clk), .i_req(w_req), .o_prod(w_prod));

    assign w_idx = r_idx[IDX_W-1:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = (r_state == S_OUT);
    assign o_tile_code = r_tile;
    assign o_hit = r_hit;
    assign o_hit_ball = r_hit_ball;

    // table read/write port; write-back lands with the last drag product
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_idx];
        if (r_state == S_DRAG && r_floor && r_sub[0]) r_mem[w_idx] <= w_wb;
        else if (r_state == S_IDLE && i_valid && i_command == CMD_LOAD)
            r_mem[i_ball_index[IDX_W-1:0]] <= '{
                pos_x: {2'b00, i_load_pos_x}, pos_y: {2'b00, i_load_pos_y},
                vel_x: i_load_vel_x, vel_y: i_load_vel_y,
                bounce: i_load_bounce, radius: i_load_radius,
                texture: i_load_texture};
    end

    // axis quantities, selected by r_sub: 0 x, 1 y
    logic signed [POS_W-1:0] w_p;
    logic signed [VEL_W-1:0] w_v;
    logic signed [19:0] w_sum, w_ps;
    logic signed [19:0] w_cell, w_r, w_size;
    logic w_lo, w_hi;
    logic signed [POS_W-1:0] w_plo, w_phi, w_pnew;
    logic signed [POS_W-1:0] w_dq;
    logic [31:0] w_lfsr_n;
    logic w_vwall, w_hwall;

    always_comb begin
        w_p = r_sub[0] ? r_cur.pos_y : r_cur.pos_x;
        w_v = r_sub[0] ? r_cur.vel_y : r_cur.vel_x;
        w_sum = 20'(w_p) + 20'(w_v);
        if (w_sum > 20'sd131071) w_ps = 20'sd131071;
        else if (w_sum < -20'sd131072) w_ps = -20'sd131072;
        else w_ps = w_sum;
        w_cell = (w_ps + ((w_ps < 0) ? 20'sd255 : 20'sd0)) >>> 8;
        w_r = 20'(r_cur.radius[10:8]);
        w_size = 20'(r_sub[0] ? r_height : r_width);
        w_lo = (w_cell - w_r) < 20'sd1;
        w_hi = (w_cell + w_r) > (w_size - 20'sd1);
        w_plo = POS_W'((w_r + 20'sd1) <<< 8);
        w_phi = POS_W'((w_size - w_r - 20'sd1) <<< 8);
        w_pnew = w_lo ? w_plo : (w_hi ? w_phi : w_ps[POS_W-1:0]);
        w_dq = POS_W'({2'b00, (r_sub[0] ? r_qy : r_qx), 8'd0}) - w_p;
        w_lfsr_n = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
        // far wall at size-1; a size of zero has no far wall column
        w_vwall = (i_query_x == 8'd0) || ({1'b0, i_query_x} == ({1'b0, r_width} - 9'd1));
        w_hwall = (i_query_y == 8'd0) || ({1'b0, i_query_y} == ({1'b0, r_height} - 9'd1));
        w_wb = r_cur;
        w_wb.vel_y = trunc16(w_prod);
    end

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_PX, S_PY: begin
                w_req.a = w_dq;
                w_req.b = w_dq;
            end
            S_PCMP: begin
                w_req.a = 18'(r_cur.radius);
                w_req.b = 18'(r_cur.radius);
            end
            S_AX, S_AY: begin
                w_req.a = 18'(w_v);
                w_req.b = {2'b00, r_cur.bounce};
            end
            S_DRAG: begin
                w_req.a = 18'(w_v);
                w_req.b = {2'b00, r_drag};
            end
            default: w_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= 8'd100; r_height <= 8'd100;
            r_drag <= 16'd65470; r_grav <= 16'sd128;
            r_jumpv <= -16'sd1536; r_chance <= 16'd328;
            r_lfsr <= 32'd1;
            r_valid_bits <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[7:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[7:0];
                    CFG_DRAG:   r_drag   <= i_cfg_data[15:0];
                    CFG_GRAV:   r_grav   <= i_cfg_data[15:0];
                    CFG_JUMPV:  r_jumpv  <= i_cfg_data[15:0];
                    CFG_CHANCE: r_chance <= i_cfg_data[15:0];
                    CFG_SEED:   r_lfsr   <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_hit <= 1'b0; r_hit_ball <= '0;
                    r_idx <= '0; r_qx <= i_query_x; r_qy <= i_query_y;
                    r_cmd_tick <= (i_command == CMD_TICK);
                    if (i_command == CMD_LOAD && 32'(i_ball_index) < BALLS)
                        r_valid_bits[i_ball_index[IDX_W-1:0]] <= 1'b1;
                    if (i_command == CMD_PIXEL && w_vwall) r_tile <= TILE_VWALL;
                    else if (i_command == CMD_PIXEL && w_hwall) r_tile <= TILE_HWALL;
                    else r_tile <= TILE_EMPTY;
                    if (i_command == CMD_TICK ||
                        (i_command == CMD_PIXEL && !w_vwall && !w_hwall))
                        r_state <= S_RD;
                    else r_state <= S_OUT;
                end
                S_RD: begin
                    if (r_idx == (IDX_W+1)'(BALLS)) r_state <= S_OUT;
                    else r_state <= S_CHK;
                end
                S_CHK: begin
                    r_cur <= r_rd;
                    r_sub <= '0;
                    if (!r_valid_bits[w_idx]) begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end else r_state <= r_cmd_tick ? S_AX : S_PX;
                end
                S_PX: begin
                    r_sub <= 3'd1;
                    r_state <= S_PY;
                end
                S_PY: begin
                    r_acc <= w_prod;
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (r_sub == 3'd1) begin
                        r_acc <= r_acc + w_prod;
                        r_sub <= 3'd2;
                    end else begin
                        if ($unsigned(r_acc) < $unsigned(w_prod)) begin
                            r_tile <= TILE_BALL0 + ((r_cur.texture > 3'd4) ? 3'd0 : r_cur.texture);
                            r_hit <= 1'b1;
                            r_hit_ball <= 7'(r_idx);
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                // r_sub[1]=0: position phase issues bounce product; 1: apply it
                S_AX, S_AY: begin
                    if (!r_sub[1]) begin
                        r_floor <= 1'b0;
                        if (r_sub[0]) r_cur.pos_y <= w_pnew;
                        else r_cur.pos_x <= w_pnew;
                        r_acc <= {34'd0, w_lo, w_hi};
                        r_sub[1] <= 1'b1;
                    end else if (r_sub[2] == 1'b0) begin
                        r_sub[2] <= 1'b1; // wait for product
                    end else begin
                        if (r_sub[0]) begin
                            // floor hit steps the LFSR and may override with a jump
                            if (!r_acc[1] && r_acc[0]) r_lfsr <= w_lfsr_n;
                            if (!r_acc[1] && r_acc[0] && w_lfsr_n[15:0] < r_chance)
                                r_cur.vel_y <= r_jumpv;
                            else if (r_acc[1:0] != 2'b00)
                                r_cur.vel_y <= -trunc16(w_prod);
                            r_state <= S_GRAV;
                        end else begin
                            if (r_acc[1:0] != 2'b00) r_cur.vel_x <= -trunc16(w_prod);
                            r_sub <= 3'd1;
                            r_state <= S_AY;
                        end
                    end
                end
                S_GRAV: begin
                    r_cur.vel_y <= sat16(18'(r_cur.vel_y) + 18'(r_grav));
                    r_sub <= 3'd0;
                    r_floor <= 1'b0;
                    r_state <= S_DRAG;
                end
                S_DRAG: begin
                    // r_floor marks the product in flight; r_sub selects axis
                    r_floor <= !r_floor;
                    if (r_floor && !r_sub[0]) begin
                        r_cur.vel_x <= trunc16(w_prod);
                        r_sub <= 3'd1;
                    end
                    if (r_floor && r_sub[0]) begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
